### sv/mrrf_pkg.sv
// Shared types, constants and CRC step function for the read request framer.
`timescale 1ns / 1ps
package mrrf_pkg;

  localparam int FRAME_LEN = 8;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  SLAVE_RESET       = 8'h01;
  localparam logic [7:0]  COUNT_HIGH        = 8'h00;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;

  localparam logic [IDX_W-1:0] POS_SLAVE     = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_FUNC      = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_ADDR_HI   = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_ADDR_LO   = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_COUNT_HI  = IDX_W'(4);
  localparam logic [IDX_W-1:0] POS_COUNT_LO  = IDX_W'(5);
  localparam logic [IDX_W-1:0] POS_CRC_LO    = IDX_W'(6);
  localparam logic [IDX_W-1:0] POS_CRC_HI    = IDX_W'(7);

  typedef struct packed {
    logic [15:0] register_address;
    logic [7:0]  word_count;
  } req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } rsp_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

### sv/mrrf_req_buf.sv
// Input holding register for one read request transaction.
`timescale 1ns / 1ps
module mrrf_req_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mrrf_pkg::req_t req,
  output logic          held_valid,
  output mrrf_pkg::req_t held,
  input  logic          take
);
  import mrrf_pkg::*;

  logic full;

  assign req_stall  = full;
  assign held_valid = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (req_valid && !full) begin
      full <= 1'b1;
    end else if (take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !full) begin
      held <= req;
    end
  end

endmodule

### sv/mrrf_serializer.sv
// Frame byte sequencer with running CRC and output register.
`timescale 1ns / 1ps
module mrrf_serializer (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     slave_address,
  input  logic           held_valid,
  input  mrrf_pkg::req_t held,
  output logic           take,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mrrf_pkg::rsp_t rsp
);
  import mrrf_pkg::*;

  logic             active;
  logic [IDX_W-1:0] idx;
  logic [15:0]      addr;
  logic [7:0]       count;
  logic [15:0]      crc;
  logic             adv;
  logic             emit;
  logic             at_last;
  logic [7:0]       byte_sel;

  always_comb begin
    adv     = !rsp_valid || !rsp_stall;
    emit    = active && adv;
    at_last = (idx == POS_CRC_HI);
    take    = held_valid && (!active || (emit && at_last));
    case (idx)
      POS_SLAVE:    byte_sel = slave_address;
      POS_FUNC:     byte_sel = FUNC_READ_HOLDING;
      POS_ADDR_HI:  byte_sel = addr[15:8];
      POS_ADDR_LO:  byte_sel = addr[7:0];
      POS_COUNT_HI: byte_sel = COUNT_HIGH;
      POS_COUNT_LO: byte_sel = count;
      POS_CRC_LO:   byte_sel = crc[7:0];
      POS_CRC_HI:   byte_sel = crc[15:8];
      default:      byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      rsp_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (adv) begin
        rsp_valid <= active;
      end
      if (take) begin
        active <= 1'b1;
        idx    <= '0;
      end else if (emit) begin
        idx <= idx + IDX_W'(1);
        if (at_last) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp.tx_byte   <= byte_sel;
      rsp.last_byte <= at_last;
      if (idx < POS_CRC_LO) begin
        crc <= crc_byte(crc, byte_sel);
      end
    end
    if (take) begin
      crc   <= CRC_INIT;
      addr  <= held.register_address;
      count <= held.word_count;
    end
  end

endmodule

### sv/modbus_read_request_framer_core.sv
// Top level: Modbus read holding registers request framer with CRC-16.
// The first frame byte passes through the request buffer, the serializer's active state and the output register.
// Throughput: one byte per cycle while rsp_stall is low, frames back to back, set by the byte sequencer.
// A request is buffered while the previous frame is still being sent.
// Reset (rst, synchronous): slave address returns to 1, all valid flags clear.
`timescale 1ns / 1ps
module modbus_read_request_framer_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  mrrf_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output mrrf_pkg::rsp_t rsp,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_data
);
  import mrrf_pkg::*;

  logic [7:0] slave_address;
  logic       held_valid;
  req_t       held;
  logic       take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slave_address <= cfg_data;
    end
  end

  mrrf_req_buf u_req_buf (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .held_valid (held_valid),
    .held       (held),
    .take       (take)
  );

  mrrf_serializer u_serializer (
    .clk           (clk),
    .rst           (rst),
    .slave_address (slave_address),
    .held_valid    (held_valid),
    .held          (held),
    .take          (take),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .rsp           (rsp)
  );

`ifndef SYNTHESIS
  a_req_fills_buffer: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request buffer not full after transaction");

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> slave_address == $past(cfg_data))
    else $error("slave address not updated by config write");

  a_last_not_repeated: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_stall && rsp.last_byte |=> !rsp_valid || !rsp.last_byte)
    else $error("last byte followed directly by another last byte");
`endif

endmodule
